/* hw/rtl/dfs_pkg.sv */
// Package with shared types and constants of the depth-first path finder.
`timescale 1ns / 1ps
`default_nettype none
package dfs_pkg;
    localparam int NODE_COUNT    = 64;
    localparam int EDGE_CAPACITY = 256;
    localparam int NODE_W  = 6;
    localparam int EPOS_W  = $clog2(EDGE_CAPACITY + 1);
    localparam int EADDR_W = (EDGE_CAPACITY > 1) ? $clog2(EDGE_CAPACITY) : 1;
    localparam int SADDR_W = $clog2(NODE_COUNT);
    localparam int DEPTH_W = $clog2(NODE_COUNT + 1);

    typedef enum logic [1:0] {
        ST_PATH    = 2'd0,
        ST_NOPATH  = 2'd1,
        ST_STORED  = 2'd2,
        ST_DROPPED = 2'd3
    } status_t;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_ADD, S_QINIT, S_CLEAR, S_TOPRD, S_SCAN, S_SCANCHK, S_POP,
        S_OUTRD, S_OUTWAIT, S_OUT, S_NOPATH
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load_item;
        logic add_edge;
        logic clear_step;
        logic push_start;
        logic read_top;
        logic scan_next;
        logic push_found;
        logic pop;
        logic out_read;
        logic out_next;
    } dp_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic op_query;
        logic query_ok;
        logic start_is_end;
        logic clear_done;
        logic scan_end;
        logic edge_hit;
        logic hit_is_end;
        logic stack_empty;
        logic out_is_last;
        logic add_ok;
    } dp_stat_t;
endpackage
`default_nettype wire

/* hw/rtl/dfs_path_finder_unit.sv */
// Top level of the depth-first path finder.
// Input requests arrive on s_tvalid/s_tready; s_tuser is the opcode
// (0 add edge, 1 query), s_tdata carries the first node in bits 5:0 and
// the second node in bits 11:6.
// Results leave on m_tvalid/m_tready: m_tuser is the status, m_tdata the
// path node and m_tlast marks the last result of a request.
// An edge request is answered from state S_ADD, which loads m_tvalid into the
// output register once that register is free.
// A query decodes, clears its marks and checks its nodes, then walks the
// edge store one entry at a time per stack level, testing for the end of
// the store in S_SCAN and the entry in S_SCANCHK through the single edge
// read port. Path nodes then stream out from the stack memory, each one
// read in S_OUTRD and sent in S_OUT.
// One request is handled at a time; s_tready is high only while idle.
// A stalled receiver holds the output register and pauses each result state.
// Reset empties the edge store, clears known nodes and drops any result.
`timescale 1ns / 1ps
`default_nettype none
module dfs_path_finder_unit
    import dfs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // first_node, second_node
    input  wire logic        s_tuser,   // opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // path_node
    output logic [1:0]       m_tuser,   // status
    output logic             m_tlast    // last_result
);
    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic [NODE_W-1:0] node_rd;
    logic [NODE_W-1:0] node_reg;
    status_t st;
    logic is_path;

    dfs_controller u_ctrl (
        .clk, .rst_n, .s_tvalid, .s_tready, .m_tvalid, .m_tready,
        .res_status(st), .res_last(m_tlast), .res_is_path(is_path),
        .stat, .cmd
    );

    dfs_datapath u_dp (
        .clk, .rst_n, .in_data({s_tdata[11:0], s_tuser}), .cmd, .stat,
        .out_node(node_rd)
    );

    // Capture the path node together with the result request.
    always_ff @(posedge clk)
    begin
        if (cmd.out_next)
            node_reg <= node_rd;
    end

    assign m_tuser = st;
    assign m_tdata = is_path ? {2'b00, node_reg} : 8'd0;
endmodule
`default_nettype wire

/* hw/rtl/dfs_datapath.sv */
// Datapath: edge store, known and visited marks, search stack and pointers.
`timescale 1ns / 1ps
`default_nettype none
module dfs_datapath
    import dfs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [12:0]       in_data,
    input  wire dp_cmd_t           cmd,
    output dp_stat_t               stat,
    output logic [NODE_W-1:0]      out_node
);
    logic [NODE_W-1:0] edge_from_mem [EDGE_CAPACITY];
    logic [NODE_W-1:0] edge_to_mem   [EDGE_CAPACITY];
    logic [NODE_W-1:0] stk_node_mem  [NODE_COUNT];
    logic [EPOS_W-1:0] stk_pos_mem   [NODE_COUNT];

    logic              op_reg;
    logic [NODE_W-1:0] a_reg, b_reg;
    logic [EPOS_W-1:0] total_reg;
    logic [NODE_COUNT-1:0] known_reg, visited_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [NODE_W-1:0]  u_reg;
    logic [EPOS_W-1:0]  p_reg;
    logic [NODE_W-1:0]  ef_rd, et_rd, sn_rd;
    logic [EPOS_W-1:0]  sp_rd;
    logic [DEPTH_W-1:0] out_idx_reg;
    logic               clr_done_reg;

    logic [SADDR_W-1:0] top_idx;
    logic [DEPTH_W-1:0] top_full;
    assign top_full = depth_reg - 1'b1;
    assign top_idx  = top_full[SADDR_W-1:0];

    // Edge store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.add_edge && total_reg < EPOS_W'(EDGE_CAPACITY))
        begin
            edge_from_mem[total_reg[EADDR_W-1:0]] <= a_reg;
            edge_to_mem[total_reg[EADDR_W-1:0]]   <= b_reg;
        end
        ef_rd <= edge_from_mem[p_reg[EADDR_W-1:0]];
        et_rd <= edge_to_mem[p_reg[EADDR_W-1:0]];
    end

    // Stack memory: pushes and position updates, registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.push_start)
        begin
            stk_node_mem[0] <= a_reg;
            stk_pos_mem[0]  <= '0;
        end
        else if (cmd.push_found)
        begin
            stk_pos_mem[top_idx] <= p_reg + 1'b1;
            if (depth_reg < DEPTH_W'(NODE_COUNT))
            begin
                stk_node_mem[depth_reg[SADDR_W-1:0]] <= et_rd;
                stk_pos_mem[depth_reg[SADDR_W-1:0]]  <= '0;
            end
        end
        if (cmd.out_read)
            sn_rd <= stk_node_mem[out_idx_reg[SADDR_W-1:0]];
        else
            sn_rd <= stk_node_mem[top_idx];
        sp_rd <= stk_pos_mem[top_idx];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg <= 1'b0; a_reg <= '0; b_reg <= '0;
            total_reg <= '0; known_reg <= '0; visited_reg <= '0;
            depth_reg <= '0; u_reg <= '0; p_reg <= '0;
            out_idx_reg <= '0; clr_done_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_item)
            begin
                op_reg <= in_data[0];
                a_reg  <= in_data[6:1];
                b_reg  <= in_data[12:7];
                clr_done_reg <= 1'b0;
            end
            if (cmd.add_edge)
            begin
                known_reg[a_reg] <= 1'b1;
                known_reg[b_reg] <= 1'b1;
                if (total_reg < EPOS_W'(EDGE_CAPACITY))
                    total_reg <= total_reg + 1'b1;
            end
            if (cmd.clear_step)
            begin
                visited_reg <= '0;
                depth_reg <= '0;
                clr_done_reg <= 1'b1;
            end
            if (cmd.push_start)
            begin
                visited_reg[a_reg] <= 1'b1;
                depth_reg <= DEPTH_W'(1);
            end
            if (cmd.read_top)
            begin
                u_reg <= sn_rd;
                p_reg <= sp_rd;
            end
            if (cmd.scan_next)
                p_reg <= p_reg + 1'b1;
            if (cmd.push_found)
            begin
                visited_reg[et_rd] <= 1'b1;
                if (depth_reg < DEPTH_W'(NODE_COUNT))
                    depth_reg <= depth_reg + 1'b1;
            end
            if (cmd.pop)
                depth_reg <= depth_reg - 1'b1;
            if (cmd.load_item)
                out_idx_reg <= '0;
            else if (cmd.out_next)
                out_idx_reg <= out_idx_reg + 1'b1;
        end
    end

    assign stat.op_query     = op_reg;
    assign stat.query_ok     = known_reg[a_reg] && known_reg[b_reg];
    assign stat.start_is_end = a_reg == b_reg;
    assign stat.clear_done   = clr_done_reg;
    assign stat.scan_end     = p_reg >= total_reg;
    assign stat.edge_hit     = ef_rd == u_reg && !visited_reg[et_rd];
    assign stat.hit_is_end   = et_rd == b_reg;
    assign stat.stack_empty  = depth_reg == '0;
    assign stat.out_is_last  = out_idx_reg + 1'b1 == depth_reg;
    assign stat.add_ok       = total_reg < EPOS_W'(EDGE_CAPACITY);
    assign out_node          = sn_rd;
endmodule
`default_nettype wire

/* hw/rtl/dfs_controller.sv */
// Controller state machine sequencing edge adds, search and path output.
`timescale 1ns / 1ps
`default_nettype none
module dfs_controller
    import dfs_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  wire logic   m_tready,
    output status_t     res_status,
    output logic        res_last,
    output logic        res_is_path,
    input  wire dp_stat_t stat,
    output dp_cmd_t     cmd
);
    state_t state_reg, state_next;
    logic   vld_reg, vld_next;
    status_t st_reg, st_next;
    logic   last_reg, last_next;
    logic   path_reg, path_next;

    // State and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; vld_reg <= 1'b0;
            st_reg <= ST_NOPATH; last_reg <= 1'b0; path_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next; vld_reg <= vld_next;
            st_reg <= st_next; last_reg <= last_next; path_reg <= path_next;
        end
    end

    logic free;
    assign free = !vld_reg || m_tready;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        vld_next = vld_reg && !m_tready;
        st_next = st_reg; last_next = last_reg; path_next = path_reg;
        s_tready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_item = 1'b1;
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                if (stat.op_query)
                    state_next = S_QINIT;
                else if (free)
                begin
                    cmd.add_edge = 1'b1;
                    vld_next = 1'b1; last_next = 1'b1; path_next = 1'b0;
                    st_next = stat.add_ok ? ST_STORED : ST_DROPPED;
                    state_next = S_IDLE;
                end
            end
            S_QINIT:
            begin
                if (!stat.clear_done)
                    cmd.clear_step = 1'b1;
                else if (!stat.query_ok)
                    state_next = S_NOPATH;
                else
                begin
                    cmd.push_start = 1'b1;
                    state_next = stat.start_is_end ? S_OUTRD : S_CLEAR;
                end
            end
            S_CLEAR: state_next = S_TOPRD;
            S_TOPRD:
            begin
                cmd.read_top = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (stat.scan_end)
                    state_next = S_POP;
                else
                    state_next = S_SCANCHK;
            end
            S_SCANCHK:
            begin
                if (stat.edge_hit)
                begin
                    cmd.push_found = 1'b1;
                    state_next = stat.hit_is_end ? S_OUTRD : S_CLEAR;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_POP:
            begin
                cmd.pop = 1'b1;
                state_next = S_OUTWAIT;
            end
            S_OUTWAIT:
                state_next = stat.stack_empty ? S_NOPATH : S_CLEAR;
            S_OUTRD:
            begin
                cmd.out_read = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (free)
                begin
                    vld_next = 1'b1; st_next = ST_PATH; path_next = 1'b1;
                    last_next = stat.out_is_last;
                    cmd.out_next = 1'b1;
                    state_next = stat.out_is_last ? S_IDLE : S_OUTRD;
                end
                else
                    cmd.out_read = 1'b1;
            end
            S_NOPATH:
            begin
                if (free)
                begin
                    vld_next = 1'b1; st_next = ST_NOPATH;
                    last_next = 1'b1; path_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign m_tvalid = vld_reg;
    assign res_status = st_reg;
    assign res_last = last_reg;
    assign res_is_path = path_reg;
endmodule
`default_nettype wire
